/* rtl/core/fcng_pkg.sv */
// Shared types and constants of the face centroid and direction glyph block.
// Holds coordinate widths, the per-face geometry record and the back-end state type.
// No dependencies.
package fcng_pkg;

    localparam int COORD_W               = 32;
    localparam int DIFF_W                = COORD_W + 1;
    localparam int COORD_FRAC_BITS       = 16;
    localparam int MAX_FACE_VERTICES_DEF = 64;
    localparam int QUEUE_DEPTH           = 2;
    localparam int DIV_BITS              = 4;
    localparam int CFG_IDX_W             = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = CFG_IDX_W'(1);

    localparam logic signed [COORD_W-1:0] SCALE_ONE = COORD_W'(64'd1 << COORD_FRAC_BITS);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    typedef struct packed {
        logic             use_cross;
        diff_t  [2:0]     edge_a;
        diff_t  [2:0]     edge_b;
        coord_t [2:0]     dir;
    } face_geom_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CALC,
        BK_CEN,
        BK_TIP,
        BK_OUT_CEN,
        BK_OUT_TIP
    } back_state_t;

endpackage

/* rtl/core/fcng_front.sv */
// Front end: accepts vertex words, accumulates per-face sums and keeps the first three vertices.
// On a face's last vertex it hands one face job to the queue.
// Depends on fcng_pkg.
module fcng_front #(
    parameter int MAX_FACE_VERTICES = fcng_pkg::MAX_FACE_VERTICES_DEF,
    localparam int CNT_W = $clog2(MAX_FACE_VERTICES + 1),
    localparam int SUM_W = fcng_pkg::COORD_W + CNT_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    orient_mode,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  fcng_pkg::coord_t        s_vertex_x,
    input  fcng_pkg::coord_t        s_vertex_y,
    input  fcng_pkg::coord_t        s_vertex_z,
    input  fcng_pkg::coord_t        s_dir_x,
    input  fcng_pkg::coord_t        s_dir_y,
    input  fcng_pkg::coord_t        s_dir_z,
    input  logic                    s_last_vertex,
    output logic                    job_valid,
    input  logic                    job_ready,
    output logic [2:0][SUM_W-1:0]   job_sum,
    output logic [CNT_W-1:0]        job_count,
    output fcng_pkg::face_geom_t    job_geom
);
    import fcng_pkg::*;

    coord_t                  vtx [3];
    coord_t                  dir_in [3];
    coord_t                  fp_reg [3][3];
    coord_t                  fp_next [3][3];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_sel [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_sel;
    logic [CNT_W-1:0]        cnt_next;
    logic                    accept;
    logic                    take;

    assign vtx[0]    = s_vertex_x;
    assign vtx[1]    = s_vertex_y;
    assign vtx[2]    = s_vertex_z;
    assign dir_in[0] = s_dir_x;
    assign dir_in[1] = s_dir_y;
    assign dir_in[2] = s_dir_z;

    // Only a closing vertex needs room in the queue.
    assign s_ready = job_ready || !s_last_vertex;
    assign accept  = s_valid && s_ready;
    assign take    = cnt_reg < CNT_W'(MAX_FACE_VERTICES);

    always_comb begin
        cnt_sel = take ? cnt_reg + 1'b1 : cnt_reg;
        for (int i = 0; i < 3; i++) begin
            sum_sel[i] = take ? sum_reg[i] + SUM_W'(vtx[i]) : sum_reg[i];
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                fp_next[k][i] = (take && cnt_reg == CNT_W'(k)) ? vtx[i] : fp_reg[k][i];
            end
        end
        if (s_last_vertex) begin
            cnt_next = '0;
            for (int i = 0; i < 3; i++) begin
                sum_next[i] = '0;
            end
        end else begin
            cnt_next = cnt_sel;
            sum_next = sum_sel;
        end
    end

    always_comb begin
        job_valid          = accept && s_last_vertex;
        job_count          = cnt_sel;
        job_geom.use_cross = orient_mode && (cnt_sel >= CNT_W'(3));
        for (int i = 0; i < 3; i++) begin
            job_sum[i]         = sum_sel[i];
            job_geom.edge_a[i] = DIFF_W'(fp_next[2][i]) - DIFF_W'(fp_next[1][i]);
            job_geom.edge_b[i] = DIFF_W'(fp_next[0][i]) - DIFF_W'(fp_next[1][i]);
            job_geom.dir[i]    = orient_mode ? '0 : dir_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (accept) begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fp_reg <= fp_next;
        end
    end

endmodule

/* rtl/core/fcng_queue.sv */
// Short first-in first-out queue of face jobs between the front and back ends.
// Register slots with a fill count; depth and word width are parameters.
// Depends on fcng_pkg for the default depth.
module fcng_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = fcng_pkg::QUEUE_DEPTH,
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;

    assign push_ready = fill_reg != FILL_W'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/fcng_back.sv */
// Back end: turns one face job into the centroid and tip result words.
// A three-lane radix-16 divider and one shared 33x33 multiplier run side by side.
// Depends on fcng_pkg.
module fcng_back #(
    parameter int MAX_FACE_VERTICES = fcng_pkg::MAX_FACE_VERTICES_DEF,
    localparam int CNT_W = $clog2(MAX_FACE_VERTICES + 1),
    localparam int SUM_W = fcng_pkg::COORD_W + CNT_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fcng_pkg::coord_t        scale_factor,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  logic [2:0][SUM_W-1:0]   job_sum,
    input  logic [CNT_W-1:0]        job_count,
    input  fcng_pkg::face_geom_t    job_geom,
    output logic                    m_valid,
    input  logic                    m_ready,
    output fcng_pkg::coord_t        m_point_x,
    output fcng_pkg::coord_t        m_point_y,
    output fcng_pkg::coord_t        m_point_z,
    output logic                    m_is_tip,
    output logic                    m_saturated
);
    import fcng_pkg::*;

    localparam int MAG_W     = ((SUM_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = MAG_W / DIV_BITS;
    localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int WIDE_W    = PROD_W + 1;

    localparam logic [3:0] MS_X_AB = 4'd0;
    localparam logic [3:0] MS_X_CD = 4'd1;
    localparam logic [3:0] MS_Y_AB = 4'd2;
    localparam logic [3:0] MS_Y_CD = 4'd3;
    localparam logic [3:0] MS_Z_AB = 4'd4;
    localparam logic [3:0] MS_Z_CD = 4'd5;
    localparam logic [3:0] MS_SX   = 4'd6;
    localparam logic [3:0] MS_SY   = 4'd7;
    localparam logic [3:0] MS_SZ   = 4'd8;

    function automatic logic [COORD_W:0] clamp_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        hi_lim = {{(WIDE_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
        lo_lim = {{(WIDE_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
        if (v > hi_lim) begin
            clamp_wide = {1'b1, 1'b0, {(COORD_W - 1){1'b1}}};
        end else if (v < lo_lim) begin
            clamp_wide = {1'b1, 1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            clamp_wide = {1'b0, v[COORD_W-1:0]};
        end
    endfunction

    back_state_t state_reg, state_next;
    logic        load_en;
    logic        calc_en;
    logic        cen_en;
    logic        tip_en;
    logic        div_done;
    logic        mul_done;

    // Divider lanes
    logic [MAG_W-1:0]   dq_reg [3];
    logic [MAG_W-1:0]   dq_next [3];
    logic [CNT_W-1:0]   rem_reg [3];
    logic [CNT_W-1:0]   rem_next [3];
    logic               neg_reg [3];
    logic [CNT_W-1:0]   den_reg;
    logic [DSTEP_W-1:0] dcnt_reg;
    logic [SUM_W-1:0]   sum_mag [3];

    // Multiplier sequence
    diff_t                    ea_reg [3];
    diff_t                    eb_reg [3];
    coord_t                   dir_reg [3];
    logic [3:0]               mstep_reg;
    logic [3:0]               pstep_reg;
    logic                     missue_reg;
    logic                     pvalid_reg;
    diff_t                    opa;
    diff_t                    opb;
    logic signed [PROD_W-1:0] prod_calc;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] phold_reg;
    logic signed [PROD_W-1:0] sc_reg [3];
    logic signed [WIDE_W-1:0] xdiff;
    logic signed [WIDE_W-1:0] xshift;
    logic [COORD_W:0]         xclamp;

    // Result words
    coord_t              cen_reg [3];
    coord_t              cen_val [3];
    coord_t              tip_reg [3];
    logic [COORD_W:0]    tip_clamp [3];
    logic                sat_reg;
    logic signed [COORD_W:0] q_ext [3];

    assign div_done = dcnt_reg == '0;
    assign mul_done = !missue_reg && !pvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC: begin
                if (div_done && mul_done) begin
                    state_next = BK_CEN;
                end
            end
            BK_CEN: begin
                state_next = BK_TIP;
            end
            BK_TIP: begin
                state_next = BK_OUT_CEN;
            end
            BK_OUT_CEN: begin
                if (m_ready) begin
                    state_next = BK_OUT_TIP;
                end
            end
            BK_OUT_TIP: begin
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        job_ready   = 1'b0;
        calc_en     = 1'b0;
        cen_en      = 1'b0;
        tip_en      = 1'b0;
        m_valid     = 1'b0;
        m_is_tip    = 1'b0;
        m_saturated = 1'b0;
        m_point_x   = cen_reg[0];
        m_point_y   = cen_reg[1];
        m_point_z   = cen_reg[2];
        case (state_reg)
            BK_IDLE: begin
                job_ready = 1'b1;
            end
            BK_CALC: begin
                calc_en = 1'b1;
            end
            BK_CEN: begin
                cen_en = 1'b1;
            end
            BK_TIP: begin
                tip_en = 1'b1;
            end
            BK_OUT_CEN: begin
                m_valid = 1'b1;
            end
            BK_OUT_TIP: begin
                m_valid     = 1'b1;
                m_is_tip    = 1'b1;
                m_saturated = sat_reg;
                m_point_x   = tip_reg[0];
                m_point_y   = tip_reg[1];
                m_point_z   = tip_reg[2];
            end
            default: begin
                job_ready = 1'b0;
            end
        endcase
    end

    assign load_en = job_ready && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Restoring division on magnitudes, DIV_BITS quotient bits per cycle.
    always_comb begin
        logic [CNT_W:0]     trial;
        logic [MAG_W-1:0]   q;
        logic [CNT_W-1:0]   r;
        for (int l = 0; l < 3; l++) begin
            q = dq_reg[l];
            r = rem_reg[l];
            for (int j = 0; j < DIV_BITS; j++) begin
                trial = {r, q[MAG_W-1]};
                q     = {q[MAG_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg}) begin
                    trial = trial - {1'b0, den_reg};
                    q[0]  = 1'b1;
                end
                r = trial[CNT_W-1:0];
            end
            dq_next[l]  = q;
            rem_next[l] = r;
            sum_mag[l]  = job_sum[l][SUM_W-1] ? (~job_sum[l] + 1'b1) : job_sum[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (load_en) begin
            dcnt_reg <= DSTEP_W'(DIV_STEPS);
        end else if (calc_en && !div_done) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            den_reg <= job_count;
            for (int l = 0; l < 3; l++) begin
                dq_reg[l]  <= MAG_W'(sum_mag[l]);
                rem_reg[l] <= '0;
                neg_reg[l] <= job_sum[l][SUM_W-1];
            end
        end else if (calc_en && !div_done) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    // Shared multiplier: six cross-product terms when use_cross is set, then three scale products.
    always_comb begin
        case (mstep_reg)
            MS_X_AB: begin opa = ea_reg[1]; opb = eb_reg[2]; end
            MS_X_CD: begin opa = ea_reg[2]; opb = eb_reg[1]; end
            MS_Y_AB: begin opa = ea_reg[2]; opb = eb_reg[0]; end
            MS_Y_CD: begin opa = ea_reg[0]; opb = eb_reg[2]; end
            MS_Z_AB: begin opa = ea_reg[0]; opb = eb_reg[1]; end
            MS_Z_CD: begin opa = ea_reg[1]; opb = eb_reg[0]; end
            MS_SX:   begin opa = DIFF_W'(scale_factor); opb = DIFF_W'(dir_reg[0]); end
            MS_SY:   begin opa = DIFF_W'(scale_factor); opb = DIFF_W'(dir_reg[1]); end
            MS_SZ:   begin opa = DIFF_W'(scale_factor); opb = DIFF_W'(dir_reg[2]); end
            default: begin opa = '0; opb = '0; end
        endcase
        prod_calc = opa * opb;
        xdiff     = WIDE_W'(phold_reg) - WIDE_W'(prod_reg);
        xshift    = xdiff >>> COORD_FRAC_BITS;
        xclamp    = clamp_wide(xshift);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missue_reg <= 1'b0;
            pvalid_reg <= 1'b0;
            mstep_reg  <= MS_X_AB;
            pstep_reg  <= MS_X_AB;
        end else if (load_en) begin
            missue_reg <= 1'b1;
            pvalid_reg <= 1'b0;
            mstep_reg  <= job_geom.use_cross ? MS_X_AB : MS_SX;
        end else if (calc_en && missue_reg) begin
            mstep_reg  <= mstep_reg + 1'b1;
            pstep_reg  <= mstep_reg;
            pvalid_reg <= 1'b1;
            if (mstep_reg == MS_SZ) begin
                missue_reg <= 1'b0;
            end
        end else begin
            pvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (calc_en && missue_reg) begin
            prod_reg <= prod_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            for (int i = 0; i < 3; i++) begin
                ea_reg[i]  <= job_geom.edge_a[i];
                eb_reg[i]  <= job_geom.edge_b[i];
                dir_reg[i] <= job_geom.dir[i];
            end
        end else if (pvalid_reg) begin
            case (pstep_reg)
                MS_X_AB, MS_Y_AB, MS_Z_AB: phold_reg <= prod_reg;
                MS_X_CD: dir_reg[0] <= xclamp[COORD_W-1:0];
                MS_Y_CD: dir_reg[1] <= xclamp[COORD_W-1:0];
                MS_Z_CD: dir_reg[2] <= xclamp[COORD_W-1:0];
                MS_SX:   sc_reg[0]  <= prod_reg >>> COORD_FRAC_BITS;
                MS_SY:   sc_reg[1]  <= prod_reg >>> COORD_FRAC_BITS;
                MS_SZ:   sc_reg[2]  <= prod_reg >>> COORD_FRAC_BITS;
                default: phold_reg  <= phold_reg;
            endcase
        end
    end

    // Floor correction: a negative sum with a remainder rounds one further down.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            q_ext[l] = {1'b0, dq_reg[l][COORD_W-1:0]};
            if (!neg_reg[l]) begin
                cen_val[l] = q_ext[l][COORD_W-1:0];
            end else if (rem_reg[l] != '0) begin
                cen_val[l] = ~q_ext[l][COORD_W-1:0];
            end else begin
                cen_val[l] = COORD_W'(-q_ext[l]);
            end
            tip_clamp[l] = clamp_wide(WIDE_W'(cen_reg[l]) + WIDE_W'(sc_reg[l]));
        end
    end

    always_ff @(posedge aclk) begin
        if (cen_en) begin
            cen_reg <= cen_val;
        end
        if (tip_en) begin
            for (int l = 0; l < 3; l++) begin
                tip_reg[l] <= tip_clamp[l][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            sat_reg <= 1'b0;
        end else if (pvalid_reg && (pstep_reg == MS_X_CD || pstep_reg == MS_Y_CD ||
                                    pstep_reg == MS_Z_CD)) begin
            sat_reg <= sat_reg | xclamp[COORD_W];
        end else if (tip_en) begin
            sat_reg <= sat_reg | tip_clamp[0][COORD_W] | tip_clamp[1][COORD_W] |
                       tip_clamp[2][COORD_W];
        end
    end

endmodule

/* rtl/core/face_centroid_normal_glyph.sv */
// Face centroid and direction glyph: top level with configuration registers and assertions.
// Vertex words are taken one per cycle while the queue has room for a face's last vertex; a
// face's two result words come once the divider and the multiplier sequence have finished its job.
// The back end takes a new face job only after both result words of the last one are taken.
// Synchronous active-low reset clears face sums, the job queue and the sequencer;
// scale_factor resets to 1.0 and orient_mode to vector mode. Depends on fcng_pkg.
module face_centroid_normal_glyph #(
    parameter int MAX_FACE_VERTICES = fcng_pkg::MAX_FACE_VERTICES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fcng_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcng_pkg::COORD_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fcng_pkg::coord_t                  s_vertex_x,
    input  fcng_pkg::coord_t                  s_vertex_y,
    input  fcng_pkg::coord_t                  s_vertex_z,
    input  fcng_pkg::coord_t                  s_dir_x,
    input  fcng_pkg::coord_t                  s_dir_y,
    input  fcng_pkg::coord_t                  s_dir_z,
    input  logic                              s_last_vertex,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fcng_pkg::coord_t                  m_point_x,
    output fcng_pkg::coord_t                  m_point_y,
    output fcng_pkg::coord_t                  m_point_z,
    output logic                              m_is_tip,
    output logic                              m_saturated
);
    import fcng_pkg::*;

    localparam int CNT_W = $clog2(MAX_FACE_VERTICES + 1);
    localparam int SUM_W = COORD_W + CNT_W;
    localparam int JOB_W = 3 * SUM_W + CNT_W + $bits(face_geom_t);

    coord_t               scale_reg;
    logic                 orient_reg;

    logic                 f_job_valid;
    logic                 q_push_ready;
    logic [2:0][SUM_W-1:0] f_sum;
    logic [CNT_W-1:0]     f_count;
    face_geom_t           f_geom;
    logic [JOB_W-1:0]     q_push_data;

    logic                 q_pop_valid;
    logic                 b_job_ready;
    logic [JOB_W-1:0]     q_pop_data;
    logic [2:0][SUM_W-1:0] b_sum;
    logic [CNT_W-1:0]     b_count;
    face_geom_t           b_geom;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_ONE;
            orient_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCALE:  scale_reg  <= cfg_wdata;
                CFG_ORIENT: orient_reg <= cfg_wdata[0];
                default:    scale_reg  <= scale_reg;
            endcase
        end
    end

    fcng_front #(
        .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .orient_mode   (orient_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_vertex_z    (s_vertex_z),
        .s_dir_x       (s_dir_x),
        .s_dir_y       (s_dir_y),
        .s_dir_z       (s_dir_z),
        .s_last_vertex (s_last_vertex),
        .job_valid     (f_job_valid),
        .job_ready     (q_push_ready),
        .job_sum       (f_sum),
        .job_count     (f_count),
        .job_geom      (f_geom)
    );

    assign q_push_data = {f_sum, f_count, f_geom};

    fcng_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_job_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (b_job_ready),
        .pop_data   (q_pop_data)
    );

    assign {b_sum, b_count, b_geom} = q_pop_data;

    fcng_back #(
        .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scale_factor (scale_reg),
        .job_valid    (q_pop_valid),
        .job_ready    (b_job_ready),
        .job_sum      (b_sum),
        .job_count    (b_count),
        .job_geom     (b_geom),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_point_z    (m_point_z),
        .m_is_tip     (m_is_tip),
        .m_saturated  (m_saturated)
    );

    // The tip word directly follows a taken centroid word.
    a_tip_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_is_tip |=> m_valid && m_is_tip)
        else $error("tip word did not follow the centroid word");

    a_cen_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_tip |-> !m_saturated)
        else $error("centroid word flagged as saturated");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        f_job_valid |-> q_push_ready)
        else $error("face job pushed into a full queue");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for face_centroid_normal_glyph: streams polygon faces and checks centroid and tip words.
// A scoreboard class predicts each face's two result words; depends on fcng_pkg and the block.
module tb;
    import fcng_pkg::*;

    localparam int LIMIT_CYCLES = 800000;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 240;
    localparam int MAX_VERTS = MAX_FACE_VERTICES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam coord_t C_MAX = 32'h7fff_ffff;
    localparam coord_t C_MIN = 32'h8000_0000;
    localparam coord_t C_NEG1 = 32'hffff_ffff;

    typedef enum int {SPAN_SMALL, SPAN_MEDIUM, SPAN_FULL, SPAN_EDGE} span_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic tip;
        logic sat;
    } glyph_point_t;

    class glyph_scoreboard;
        glyph_point_t expected_points[$];
        longint face_sum[3];
        longint corner[9];
        int unsigned face_verts;
        coord_t scale;
        logic orient;
        bit tip_clip;
        int errors;
        int seen;

        function new();
            face_sum = '{0, 0, 0};
            corner = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
            face_verts = 0;
            scale = SCALE_ONE;
            orient = 1'b0;
            errors = 0;
            seen = 0;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
            if (idx == CFG_SCALE) begin
                scale = data;
            end else if (idx == CFG_ORIENT) begin
                orient = data[0];
            end
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) begin
                tip_clip = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                tip_clip = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint normal_term(longint a, longint b, longint c, longint d);
            logic signed [69:0] pa, pb, pc, pd, diff;
            longint v;
            pa = a;
            pb = b;
            pc = c;
            pd = d;
            diff = pa * pb - pc * pd;
            diff = diff >>> COORD_FRAC_BITS;
            v = longint'(diff);
            return clip32(v);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH: %s", msg);
        endtask

        function void note_vertex(coord_t vx, coord_t vy, coord_t vz,
                                  coord_t dx, coord_t dy, coord_t dz, logic last);
            longint pos[3], dirv[3], cen[3], ea[3], eb[3], n, sc, t;
            glyph_point_t cp, tp;
            pos[0] = vx;
            pos[1] = vy;
            pos[2] = vz;
            if (face_verts < MAX_VERTS) begin
                for (int i = 0; i < 3; i++) begin
                    face_sum[i] += pos[i];
                    if (face_verts < 3) corner[face_verts * 3 + i] = pos[i];
                end
                face_verts++;
            end
            if (!last) return;

            n = face_verts;
            for (int i = 0; i < 3; i++) begin
                cen[i] = face_sum[i] / n;
                if (face_sum[i] % n != 0 && face_sum[i] < 0) cen[i]--;
            end

            tip_clip = 1'b0;
            if (!orient) begin
                dirv[0] = dx;
                dirv[1] = dy;
                dirv[2] = dz;
            end else if (face_verts < 3) begin
                dirv = '{0, 0, 0};
            end else begin
                for (int i = 0; i < 3; i++) begin
                    ea[i] = corner[6 + i] - corner[3 + i];
                    eb[i] = corner[i] - corner[3 + i];
                end
                dirv[0] = normal_term(ea[1], eb[2], ea[2], eb[1]);
                dirv[1] = normal_term(ea[2], eb[0], ea[0], eb[2]);
                dirv[2] = normal_term(ea[0], eb[1], ea[1], eb[0]);
            end

            sc = scale;
            cp.x = 32'(cen[0]);
            cp.y = 32'(cen[1]);
            cp.z = 32'(cen[2]);
            cp.tip = 1'b0;
            cp.sat = 1'b0;
            t = clip32(cen[0] + ((sc * dirv[0]) >>> COORD_FRAC_BITS));
            tp.x = 32'(t);
            t = clip32(cen[1] + ((sc * dirv[1]) >>> COORD_FRAC_BITS));
            tp.y = 32'(t);
            t = clip32(cen[2] + ((sc * dirv[2]) >>> COORD_FRAC_BITS));
            tp.z = 32'(t);
            tp.tip = 1'b1;
            tp.sat = tip_clip;
            expected_points.push_back(cp);
            expected_points.push_back(tp);

            face_sum = '{0, 0, 0};
            face_verts = 0;
        endfunction

        task check_point(coord_t x, coord_t y, coord_t z, logic tip, logic sat);
            glyph_point_t w;
            seen++;
            if (expected_points.size() == 0) begin
                report($sformatf("word %0d: %h %h %h tip %b sat %b with nothing expected",
                                 seen, x, y, z, tip, sat));
                return;
            end
            w = expected_points.pop_front();
            if (x !== w.x || y !== w.y || z !== w.z || tip !== w.tip || sat !== w.sat) begin
                report($sformatf("word %0d: got %h %h %h tip %b sat %b, want %h %h %h tip %b sat %b",
                                 seen, x, y, z, tip, sat, w.x, w.y, w.z, w.tip, w.sat));
            end
        endtask
    endclass

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    coord_t s_vertex_x, s_vertex_y, s_vertex_z;
    coord_t s_dir_x, s_dir_y, s_dir_z;
    logic s_last_vertex;
    logic m_valid;
    logic m_ready;
    coord_t m_point_x, m_point_y, m_point_z;
    logic m_is_tip;
    logic m_saturated;

    glyph_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int cycles = 0;

    face_centroid_normal_glyph dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vertex_x   (s_vertex_x),
        .s_vertex_y   (s_vertex_y),
        .s_vertex_z   (s_vertex_z),
        .s_dir_x      (s_dir_x),
        .s_dir_y      (s_dir_y),
        .s_dir_z      (s_dir_z),
        .s_last_vertex(s_last_vertex),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_point_z    (m_point_z),
        .m_is_tip     (m_is_tip),
        .m_saturated  (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_point(m_point_x, m_point_y, m_point_z, m_is_tip, m_saturated);
            end
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic coord_t pick_coord(span_t span);
        logic [31:0] r;
        r = $urandom;
        case (span)
            SPAN_SMALL: return {{14{r[17]}}, r[17:0]};
            SPAN_MEDIUM: return {{6{r[25]}}, r[25:0]};
            SPAN_EDGE: begin
                case ($urandom_range(4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    3: return C_NEG1;
                    default: return SCALE_ONE;
                endcase
            end
            default: return r;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic send_vertex(coord_t vx, coord_t vy, coord_t vz,
                               coord_t dx, coord_t dy, coord_t dz, logic last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_vertex_x <= vx;
        s_vertex_y <= vy;
        s_vertex_z <= vz;
        s_dir_x <= dx;
        s_dir_y <= dy;
        s_dir_z <= dz;
        s_last_vertex <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_vertex(vx, vy, vz, dx, dy, dz, last);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_faces(int words);
        int sent;
        int len;
        int pick;
        span_t pos_span;
        span_t dir_span;
        sent = 0;
        while (sent < words) begin
            pick = $urandom_range(99);
            if (pick < 5) len = 1;
            else if (pick < 10) len = 2;
            else if (pick < 95) len = $urandom_range(3, 8);
            else if (pick < 99) len = $urandom_range(9, 30);
            else len = $urandom_range(MAX_VERTS - 4, MAX_VERTS + 6);
            pos_span = span_t'($urandom_range(3));
            dir_span = span_t'($urandom_range(3));
            for (int k = 0; k < len; k++) begin
                send_vertex(pick_coord(pos_span), pick_coord(pos_span), pick_coord(pos_span),
                            pick_coord(dir_span), pick_coord(dir_span), pick_coord(dir_span),
                            k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        coord_t phase_scale;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_vertex_x = '0;
        s_vertex_y = '0;
        s_vertex_z = '0;
        s_dir_x = '0;
        s_dir_y = '0;
        s_dir_z = '0;
        s_last_vertex = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_vertex(C_MAX, C_MIN, '0, C_MAX, C_MIN, C_NEG1, 1'b1);
        send_vertex(C_NEG1, -32'sd3, 32'sd5, '0, '0, '0, 1'b0);
        send_vertex('0, '0, '0, 32'sd1, '0, -SCALE_ONE, 1'b1);
        send_vertex(C_MIN, C_MIN, C_MIN, '0, '0, '0, 1'b0);
        send_vertex(C_MIN, C_MIN, C_MIN, '0, '0, '0, 1'b0);
        send_vertex(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
        settle();

        write_reg(CFG_SCALE, C_MAX);
        write_reg(CFG_ORIENT, 32'd1);
        send_vertex(C_MAX, C_MIN, C_MAX, '0, '0, '0, 1'b0);
        send_vertex(C_MIN, C_MAX, C_MIN, '0, '0, '0, 1'b0);
        send_vertex(C_MAX, C_MAX, C_MIN, '0, '0, '0, 1'b1);
        send_vertex(SCALE_ONE, C_NEG1, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, 32'sd7, '0, C_MAX, C_MAX, C_MAX, 1'b1);
        send_vertex('0, '0, '0, '0, '0, '0, 1'b0);
        send_vertex(SCALE_ONE, '0, '0, '0, '0, '0, 1'b0);
        send_vertex('0, SCALE_ONE, '0, '0, '0, '0, 1'b1);
        settle();

        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        write_reg(CFG_SCALE, C_MIN);
        for (int k = 0; k < 4; k++) begin
            send_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, k == 3);
        end
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: phase_scale = SCALE_ONE;
                1: phase_scale = C_MAX;
                2: phase_scale = C_MIN;
                4: phase_scale = '0;
                5: phase_scale = -SCALE_ONE;
                6: phase_scale = pick_coord(SPAN_SMALL);
                default: phase_scale = $urandom;
            endcase
            write_reg(CFG_SCALE, phase_scale);
            write_reg(CFG_ORIENT, {31'd0, ph[0]});
            case (ph % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 48;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 48;
                end
                default: begin
                    src_idle_pct = 21;
                    sink_stall_pct = 21;
                end
            endcase
            if (ph == 0 || ph == 4) hold_requests++;
            run_faces(PHASE_WORDS);
            settle();
        end

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
